@@ rtl/opl_pkg.sv @@
// package for the ordered position list engine
// shared constants, operation codes and cell control struct; no dependencies
package opl_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int MODE_W      = 4;
    localparam int COORD_W     = 16;
    localparam int GRID_W      = 15;
    localparam int CNT_W       = 7;
    localparam int STAT_W      = 2;
    localparam logic [GRID_W-1:0] GRID_RST = 15'd16;

    localparam logic [MODE_W-1:0] OP_APPEND  = 4'd0;
    localparam logic [MODE_W-1:0] OP_DEL_FST = 4'd1;
    localparam logic [MODE_W-1:0] OP_DEL_LST = 4'd2;
    localparam logic [MODE_W-1:0] OP_DEL_MAT = 4'd3;
    localparam logic [MODE_W-1:0] OP_SEARCH  = 4'd4;
    localparam logic [MODE_W-1:0] OP_ROTATE  = 4'd5;
    localparam logic [MODE_W-1:0] OP_ADD_OFS = 4'd6;
    localparam logic [MODE_W-1:0] OP_SHIFT   = 4'd7;
    localparam logic [MODE_W-1:0] OP_EXTRACT = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic               shl;   // all cells take right neighbor (one chain step)
        logic               add;   // all cells add offset
        logic               sft;   // all cells take left neighbor, head takes shift_val
        logic               wr;    // write cell at wr_idx (after the chain step)
        logic [5:0]         wr_idx;
        logic [COORD_W-1:0] add_r;
        logic [COORD_W-1:0] add_c;
        logic [2*COORD_W-1:0] wr_val;
    } t_cell_ctl;

endpackage

@@ rtl/opl_if.sv @@
// valid/ready channel interface with generic payload
// depends on nothing
interface opl_if #(parameter int W = 32) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/opl_cell.sv @@
// one storage cell of the position chain; holds a (row, column) pair
// depends on opl_pkg
module opl_cell (
    input  logic                         i_clk,
    input  opl_pkg::t_cell_ctl           i_ctl,
    input  logic                         i_sel,
    input  logic [2*opl_pkg::COORD_W-1:0] i_left,
    input  logic [2*opl_pkg::COORD_W-1:0] i_right,
    input  logic [2*opl_pkg::COORD_W-1:0] i_head,
    input  logic                         i_is_head,
    output logic [2*opl_pkg::COORD_W-1:0] o_val
);
    import opl_pkg::*;
    logic [2*COORD_W-1:0] r_val;
    logic [2*COORD_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.add) begin
            n_val = {r_val[2*COORD_W-1:COORD_W] + i_ctl.add_r,
                     r_val[COORD_W-1:0] + i_ctl.add_c};
        end else if (i_ctl.sft) begin
            n_val = i_is_head ? i_head : i_left;
        end else begin
            if (i_ctl.shl) begin
                n_val = i_right;
            end
            // the wr_idx slot takes a new entry or the kept old head
            if (i_ctl.wr && i_sel) begin
                n_val = i_ctl.wr_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end
    assign o_val = r_val;
endmodule

@@ rtl/opl_ctrl.sv @@
// sequencer: steps the chain one place per cycle in walking operations but stalls
// while an extract hit waits for the result register; depends on opl_pkg
module opl_ctrl #(
    parameter int DEPTH = opl_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [opl_pkg::MODE_W-1:0]    i_mode,
    input  logic [opl_pkg::COORD_W-1:0]   i_row,
    input  logic [opl_pkg::COORD_W-1:0]   i_col,
    input  logic [opl_pkg::GRID_W-1:0]    i_grid,
    input  logic [2*opl_pkg::COORD_W-1:0] i_head,   // cell 0
    output opl_pkg::t_cell_ctl            o_ctl,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2*opl_pkg::COORD_W+2+opl_pkg::CNT_W+opl_pkg::STAT_W-1:0] o_out
);
    import opl_pkg::*;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]         r_st;
    logic [MODE_W-1:0]  r_mode;
    logic [COORD_W-1:0] r_row, r_col;
    logic [CNT_W-1:0]   r_cnt;     // entries held
    logic [CNT_W-1:0]   r_len;     // entries in the chain during a walk
    logic [CNT_W-1:0]   r_left;    // chain steps still to do
    logic               r_hit;     // del match already removed one
    logic               r_found;
    logic [CNT_W-1:0]   r_nx;      // extract hits counted in the first pass
    logic [CNT_W-1:0]   r_ne;      // extract hits emitted so far
    logic               r_ov;
    logic [2*COORD_W+2+CNT_W+STAT_W-1:0] r_out;

    logic [COORD_W-1:0] hr, hc;
    logic               hit_pos, hit_col;
    logic [COORD_W-1:0] sr0, sc0, sr1, sc1;
    logic [2*COORD_W-1:0] shv;
    logic [COORD_W-1:0] gm;
    logic               keep;
    logic               go;
    logic [CNT_W-1:0]   len_nx;
    logic [CNT_W-1:0]   len_m1;
    logic [CNT_W-1:0]   nx_sum;
    logic               in_acc;

    assign hr = i_head[2*COORD_W-1:COORD_W];
    assign hc = i_head[COORD_W-1:0];
    assign hit_pos = (hr == r_row) && (hc == r_col);
    assign hit_col = (hc == r_col);
    assign gm = {1'b0, i_grid};

    always_comb begin
        sr0 = hr + i_row;
        sc0 = hc + i_col;
        sr1 = ($signed(sr0) > $signed(gm)) ? 16'd1 : sr0;
        sc1 = ($signed(sc0) > $signed(gm)) ? 16'd1 : sc0;
        if ($signed(sr1) < 16'sd1) sr1 = gm;
        if ($signed(sc1) < 16'sd1) sc1 = gm;
        shv = {sr1, sc1};
    end

    assign o_in_ready = (r_st == S_IDLE) && !r_ov;
    assign o_out_valid = r_ov;
    assign o_out = r_out;
    assign in_acc = i_in_valid && o_in_ready;

    function automatic logic [2*COORD_W+2+CNT_W+STAT_W-1:0] pack(
        logic f, logic [2*COORD_W-1:0] v, logic l, logic [CNT_W-1:0] n,
        logic [STAT_W-1:0] s);
        pack = {f, v, l, n, s};
    endfunction

    // each chain step looks at cell 0, shifts all cells one place toward the head
    // and, when the old head is kept, writes it into the last slot of the chain
    always_comb begin
        keep = 1'b1;
        if (r_st == S_WALK) begin
            case (r_mode)
                OP_DEL_FST: keep = 1'b0;
                OP_DEL_MAT: keep = !(hit_pos && !r_hit);
                OP_EXTRACT: keep = !hit_col;
                default:    keep = 1'b1;
            endcase
        end
    end

    // an extract hit waits for a free result register
    assign go = !((r_st == S_WALK) && (r_mode == OP_EXTRACT) && !keep && r_ov);
    assign len_m1 = r_len - ONE_C;
    assign len_nx = keep ? r_len : len_m1;
    assign nx_sum = r_nx + CNT_W'(hit_col);

    always_comb begin
        o_ctl = '0;
        o_ctl.add_r = i_row;
        o_ctl.add_c = i_col;
        o_ctl.wr_val = {i_row, i_col};
        o_ctl.wr_idx = r_cnt[5:0];
        if (in_acc && r_cnt != '0) begin
            case (i_mode)
                OP_ADD_OFS: o_ctl.add = 1'b1;
                OP_SHIFT: begin
                    o_ctl.sft = 1'b1;
                    o_ctl.wr_val = shv;
                end
                default: ;
            endcase
        end
        if (in_acc && i_mode == OP_APPEND && r_cnt != DEPTH_C) o_ctl.wr = 1'b1;
        if ((r_st == S_SCAN || r_st == S_WALK) && go) begin
            o_ctl.shl = 1'b1;
            o_ctl.wr = keep;
            o_ctl.wr_idx = len_m1[5:0];
            o_ctl.wr_val = i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode <= i_mode;
                        r_row <= i_row;
                        r_col <= i_col;
                        r_len <= r_cnt;
                        r_left <= (i_mode == OP_DEL_FST || i_mode == OP_ROTATE) ?
                                  ONE_C : r_cnt;
                        r_hit <= 1'b0;
                        r_found <= 1'b0;
                        r_nx <= '0;
                        r_ne <= '0;
                        if (i_mode > OP_EXTRACT) begin
                            r_ov <= 1'b1;
                            r_out <= pack(1'b0, r_cnt != '0 ? i_head : '0, 1'b1,
                                          r_cnt, ST_OK);
                        end else if (i_mode == OP_APPEND) begin
                            r_ov <= 1'b1;
                            if (r_cnt == DEPTH_C) begin
                                r_out <= pack(1'b0, i_head, 1'b1, r_cnt, ST_FULL);
                            end else begin
                                r_cnt <= r_cnt + 1'b1;
                                r_out <= pack(1'b0, r_cnt != '0 ? i_head :
                                              {i_row, i_col}, 1'b1,
                                              r_cnt + 1'b1, ST_OK);
                            end
                        end else if (r_cnt == '0) begin
                            r_ov <= 1'b1;
                            r_out <= pack(1'b0, '0, 1'b1, r_cnt, ST_EMPTY);
                        end else if (i_mode == OP_DEL_LST) begin
                            r_cnt <= r_cnt - 1'b1;
                            r_ov <= 1'b1;
                            r_out <= pack(1'b0, r_cnt != ONE_C ? i_head : '0,
                                          1'b1, r_cnt - 1'b1, ST_OK);
                        end else if (i_mode == OP_ADD_OFS || i_mode == OP_SHIFT) begin
                            r_st <= S_OUT;
                        end else if (i_mode == OP_EXTRACT) begin
                            r_st <= S_SCAN;
                        end else begin
                            r_st <= S_WALK;
                        end
                    end
                end
                S_SCAN: begin
                    // first extract pass only counts hits, the chain comes back in order
                    r_nx <= nx_sum;
                    if (r_left == ONE_C) begin
                        r_len <= r_cnt;
                        r_left <= r_cnt;
                        r_st <= (nx_sum == '0) ? S_OUT : S_WALK;
                    end else begin
                        r_left <= r_left - ONE_C;
                    end
                end
                S_WALK: begin
                    if (go) begin
                        r_left <= r_left - ONE_C;
                        r_len <= len_nx;
                        if (r_mode == OP_DEL_MAT && !keep) begin
                            r_hit <= 1'b1;
                            r_found <= 1'b1;
                        end
                        if (r_mode == OP_SEARCH && hit_pos) r_found <= 1'b1;
                        if (r_mode == OP_EXTRACT && !keep) begin
                            r_ov <= 1'b1;
                            r_ne <= r_ne + ONE_C;
                            r_out <= pack(1'b1, i_head, (r_ne + ONE_C) == r_nx,
                                          r_cnt - r_nx, ST_OK);
                        end
                        if (r_left == ONE_C) begin
                            r_cnt <= len_nx;
                            r_st <= (r_mode == OP_EXTRACT) ? S_IDLE : S_OUT;
                        end
                    end
                end
                default: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_st <= S_IDLE;
                        r_out <= pack(r_found, r_cnt != '0 ? i_head : '0, 1'b1,
                                      r_cnt, ST_OK);
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)));
    a_cnt_max: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        r_cnt <= DEPTH_C);
    a_walk_len: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        (r_st == S_WALK) |-> (r_len <= r_cnt));
    a_in_idle: assert property (@(posedge i_clk) disable iff (i_rst_n !== 1'b1)
        o_in_ready |-> (r_st == S_IDLE && !o_out_valid));
`endif
endmodule

@@ rtl/ordered_position_list_engine_unit.sv @@
// top level of the ordered position list engine
// depends on opl_pkg, opl_if, opl_cell, opl_ctrl
// usage: requests arrive on i_req {mode, row, col}, results leave on o_rsp.
// grid_max is written through i_cfg between requests; reset value 16.
// one request is worked on at a time; with n entries held, the way from accept
// to the first result valid is:
//   append, delete last, empty list, unused codes: result registered on accept
//   add offset and shift move: all cells update together, then the result
//   delete first and rotate: a single step of the cell chain, then the result
//   search and delete match: the chain turns once through cell 0
//   extract without a hit: a counting pass, then the result; with hits the
//   counting pass, then a second pass that emits the hits in order, each hit
//   holding the chain until the receiver has taken the one before
// a new request is taken the cycle after the last result is accepted.
// reset clears the entry count and sets grid_max to 16; cells hold no reset value.
// a stalled receiver holds the result, stops the extract pass and blocks i_req.
module ordered_position_list_engine_unit #(
    parameter int DEPTH = opl_pkg::DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    opl_if.sink   i_req,
    opl_if.sink   i_cfg,
    opl_if.source o_rsp
);
    import opl_pkg::*;
    logic [GRID_W-1:0] r_grid;
    t_cell_ctl         ctl;
    logic [2*COORD_W-1:0] vals [DEPTH];

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_grid <= GRID_RST;
        else if (i_cfg.valid) r_grid <= i_cfg.data[GRID_W-1:0];
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        opl_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_sel    (ctl.wr_idx == 6'(g)),
            .i_left   (vals[(g + DEPTH - 1) % DEPTH]),
            .i_right  (vals[(g + 1) % DEPTH]),
            .i_head   (ctl.wr_val),
            .i_is_head(g == 0),
            .o_val    (vals[g])
        );
    end

    opl_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_mode     (i_req.data[MODE_W+2*COORD_W-1:2*COORD_W]),
        .i_row      (i_req.data[2*COORD_W-1:COORD_W]),
        .i_col      (i_req.data[COORD_W-1:0]),
        .i_grid     (r_grid),
        .i_head     (vals[0]),
        .o_ctl      (ctl),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .o_out      (o_rsp.data)
    );
endmodule
